@@ rtl/sha1mh_pkg.sv @@
package sha1mh_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int LEN_SLOT     = 14;

    localparam int BUF_AW   = $clog2(BLOCK_WORDS);
    localparam int CHAIN_AW = $clog2(DIGEST_WORDS);
    localparam int T_W      = $clog2(ROUNDS);

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    typedef struct packed {
        logic           shift;
        logic           step;
        logic [T_W-1:0] t;
    } t_round_ctl;

    function automatic logic [31:0] h_init(input logic [CHAIN_AW-1:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6745_2301;
            3'd1:    v = 32'hEFCD_AB89;
            3'd2:    v = 32'h98BA_DCFE;
            3'd3:    v = 32'h1032_5476;
            3'd4:    v = 32'hC3D2_E1F0;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [T_W-1:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = 32'h5A82_7999;
        end else if (t < 7'd40) begin
            k = 32'h6ED9_EBA1;
        end else if (t < 7'd60) begin
            k = 32'h8F1B_BCDC;
        end else begin
            k = 32'hCA62_C1D6;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [T_W-1:0] t,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

@@ rtl/sha1mh_if.sv @@
interface sha1mh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;

    modport source (output valid, output data_word, output byte_count,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input end_of_message, output ready);
endinterface

interface sha1mh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, output digest_word, output word_index,
                    output final_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input final_word, output ready);
endinterface

@@ rtl/sha1mh_ram.sv @@
module sha1mh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sha1mh_round.sv @@
module sha1mh_round (
    input  logic                   i_clk,
    input  sha1mh_pkg::t_round_ctl i_ctl,
    input  logic [31:0]            i_h_word,
    input  logic [31:0]            i_buf_word,
    output logic [31:0]            o_a
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_sched [sha1mh_pkg::BLOCK_WORDS];
    logic [31:0] sched_x;
    logic [31:0] w_word;
    logic [31:0] sum;

    // sched[15] is the newest word, sched[0] the one sixteen rounds back
    assign sched_x = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
    assign w_word  = (i_ctl.t < 7'(sha1mh_pkg::BLOCK_WORDS)) ? i_buf_word
                                                             : {sched_x[30:0], sched_x[31]};
    assign sum = {r_a[26:0], r_a[31:27]}
               + sha1mh_pkg::round_f(i_ctl.t, r_b, r_c, r_d)
               + r_e
               + sha1mh_pkg::round_k(i_ctl.t)
               + w_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= i_h_word;
        end else if (i_ctl.step) begin
            r_a <= sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
            for (int i = 0; i < sha1mh_pkg::BLOCK_WORDS - 1; i++) begin
                r_sched[i] <= r_sched[i+1];
            end
            r_sched[sha1mh_pkg::BLOCK_WORDS-1] <= w_word;
        end
    end

    assign o_a = r_a;

endmodule

@@ rtl/sha1_message_hasher_unit.sv @@
// SHA-1 message hasher.
// Input channel i_in carries the message as big-endian 32-bit words, first byte in
// bits 31:24; byte_count (0..4) matters only on the beat with end_of_message set.
// Output channel o_out returns five digest words, H0 first, the last one flagged
// with final_word. Both channels transfer a beat when valid and ready are high.
// A word that neither fills the block nor ends the message leaves the input ready.
// The sixteenth word of a block starts a compression: the chaining state is loaded
// from its memory, 80 rounds run at one per cycle and the results are added back,
// so the block rate is set by the single round unit. The final word adds the
// padding words and one or two compressions, then each digest word is read from the
// chaining-state memory.
// The input is not ready while a compression or the padding runs.
// The digest sits in an output register; a stalled receiver holds the remaining
// digest words back, and the next message may start once the last word is loaded.
// Reset (i_rst_n low, synchronous) restores the initial chaining values, clears
// the bit count and buffer position and drops any pending digest word; no
// clearing pass is needed.
module sha1_message_hasher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sha1mh_in_if.sink          i_in,
    sha1mh_out_if.source       o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_HLOAD = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_HADD  = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OWAIT = 3'd6;

    localparam logic [1:0] PH_80     = 2'd0;
    localparam logic [1:0] PH_ZERO   = 2'd1;
    localparam logic [1:0] PH_LEN_LO = 2'd2;

    localparam int BAW = sha1mh_pkg::BUF_AW;
    localparam int CAW = sha1mh_pkg::CHAIN_AW;
    localparam int TW  = sha1mh_pkg::T_W;

    localparam logic [BAW-1:0] LAST_POS = BAW'(sha1mh_pkg::BLOCK_WORDS - 1);
    localparam logic [BAW-1:0] LEN_POS  = BAW'(sha1mh_pkg::LEN_SLOT);
    localparam logic [CAW-1:0] CNT_END  = CAW'(sha1mh_pkg::DIGEST_WORDS);
    localparam logic [CAW-1:0] IDX_LAST = CAW'(sha1mh_pkg::DIGEST_WORDS - 1);
    localparam logic [TW-1:0]  T_LAST   = TW'(sha1mh_pkg::ROUNDS - 1);

    logic [2:0]     r_state, n_state;
    logic [2:0]     r_ret, n_ret;
    logic [1:0]     r_phase, n_phase;
    logic [BAW-1:0] r_pos, n_pos;
    logic [63:0]    r_bits, n_bits;
    logic [CAW-1:0] r_cnt, n_cnt;
    logic [TW-1:0]  r_t, n_t;
    logic [sha1mh_pkg::DIGEST_WORDS-1:0] r_hvalid, n_hvalid;
    logic [CAW-1:0] r_idx, n_idx;
    logic           r_init_sel;
    logic [CAW-1:0] r_init_idx;

    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_out_word;
    logic [2:0]     r_out_idx;
    logic           r_out_final;
    logic           load_out;

    logic           in_acc;
    logic [2:0]     count_c;
    logic [5:0]     sh;
    logic [5:0]     inc;
    logic [31:0]    word_c;

    logic           buf_we, buf_re;
    logic [BAW-1:0] buf_raddr;
    logic [31:0]    buf_wdata, buf_rdata;

    logic           chain_we, chain_re;
    logic [CAW-1:0] chain_waddr, chain_raddr;
    logic [31:0]    chain_wdata, chain_rdata;
    logic [31:0]    h_word;
    logic [31:0]    a_word;

    sha1mh_pkg::t_round_ctl ctl;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // clamp the byte count; a word that is not last always counts as four bytes
    assign count_c = (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;
    assign sh      = {count_c, 3'b000};
    assign inc     = i_in.end_of_message ? sh : 6'd32;
    assign word_c  = i_in.end_of_message
                   ? ((i_in.data_word & ~(32'hFFFF_FFFF >> sh))
                      | (sha1mh_pkg::PAD_WORD >> sh))
                   : i_in.data_word;

    // entries never written since reset read as the initial chaining value
    assign h_word = r_init_sel ? sha1mh_pkg::h_init(r_init_idx) : chain_rdata;

    assign chain_waddr = r_cnt - CAW'(1);
    assign chain_wdata = h_word + a_word;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_t         = r_t;
        n_hvalid    = r_hvalid;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        load_out    = 1'b0;
        buf_we      = 1'b0;
        buf_wdata   = word_c;
        buf_re      = 1'b0;
        buf_raddr   = '0;
        chain_we    = 1'b0;
        chain_re    = 1'b0;
        chain_raddr = r_cnt;
        ctl         = '0;
        ctl.t       = r_t;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    buf_we = 1'b1;
                    n_bits = r_bits + {58'd0, inc};
                    n_pos  = r_pos + BAW'(1);
                    if (i_in.end_of_message) begin
                        n_phase = (count_c == 3'd4) ? PH_80 : PH_ZERO;
                    end
                    if (r_pos == LAST_POS) begin
                        n_state = S_HLOAD;
                        n_cnt   = '0;
                        n_ret   = i_in.end_of_message ? S_PAD : S_IDLE;
                    end else if (i_in.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                buf_we = 1'b1;
                case (r_phase)
                    PH_80: begin
                        buf_wdata = sha1mh_pkg::PAD_WORD;
                        n_phase   = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (r_pos == LEN_POS) begin
                            buf_wdata = r_bits[63:32];
                            n_phase   = PH_LEN_LO;
                        end else begin
                            buf_wdata = 32'd0;
                        end
                    end
                    default: begin
                        buf_wdata = r_bits[31:0];
                    end
                endcase
                n_pos = r_pos + BAW'(1);
                if (r_pos == LAST_POS) begin
                    n_state = S_HLOAD;
                    n_cnt   = '0;
                    n_ret   = (r_phase == PH_LEN_LO) ? S_ORD : S_PAD;
                end
            end
            S_HLOAD: begin
                chain_re  = (r_cnt != CNT_END);
                ctl.shift = (r_cnt != '0);
                if (r_cnt == CNT_END) begin
                    buf_re    = 1'b1;
                    buf_raddr = '0;
                    n_state   = S_ROUND;
                    n_t       = '0;
                end else begin
                    n_cnt = r_cnt + CAW'(1);
                end
            end
            S_ROUND: begin
                ctl.step  = 1'b1;
                buf_re    = 1'b1;
                buf_raddr = r_t[BAW-1:0] + BAW'(1);
                if (r_t == T_LAST) begin
                    n_state = S_HADD;
                    n_cnt   = '0;
                end else begin
                    n_t = r_t + TW'(1);
                end
            end
            S_HADD: begin
                chain_re = (r_cnt != CNT_END);
                if (r_cnt != '0) begin
                    chain_we              = 1'b1;
                    ctl.shift             = 1'b1;
                    n_hvalid[chain_waddr] = 1'b1;
                end
                if (r_cnt == CNT_END) begin
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt + CAW'(1);
                end
            end
            S_ORD: begin
                chain_re    = 1'b1;
                chain_raddr = r_idx;
                n_state     = S_OWAIT;
            end
            S_OWAIT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        // start the next message from the initial state
                        n_hvalid = '0;
                        n_bits   = '0;
                        n_pos    = '0;
                        n_idx    = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CAW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_phase     <= PH_80;
            r_pos       <= '0;
            r_bits      <= '0;
            r_cnt       <= '0;
            r_t         <= '0;
            r_hvalid    <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_bits      <= n_bits;
            r_cnt       <= n_cnt;
            r_t         <= n_t;
            r_hvalid    <= n_hvalid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_re) begin
            r_init_sel <= !r_hvalid[chain_raddr];
            r_init_idx <= chain_raddr;
        end
        if (load_out) begin
            r_out_word  <= h_word;
            r_out_idx   <= 3'(r_idx);
            r_out_final <= (r_idx == IDX_LAST);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_word = r_out_word;
    assign o_out.word_index  = r_out_idx;
    assign o_out.final_word  = r_out_final;

    sha1mh_ram #(
        .WIDTH (32),
        .DEPTH (sha1mh_pkg::BLOCK_WORDS)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_pos),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    sha1mh_ram #(
        .WIDTH (32),
        .DEPTH (sha1mh_pkg::DIGEST_WORDS)
    ) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_waddr (chain_waddr),
        .i_wdata (chain_wdata),
        .i_re    (chain_re),
        .i_raddr (chain_raddr),
        .o_rdata (chain_rdata)
    );

    sha1mh_round u_round (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_h_word   (h_word),
        .i_buf_word (buf_rdata),
        .o_a        (a_word)
    );

`ifndef SYNTHESIS
    a_chain_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_we && chain_re |-> chain_waddr != chain_raddr)
        else $error("chain state read and write hit the same entry");

    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HLOAD && $past(r_state) != S_HLOAD |-> r_pos == '0)
        else $error("compression started on a partial block");

    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAD && r_phase == PH_LEN_LO |-> r_pos == LAST_POS)
        else $error("length low word not in the last block slot");

    a_buf_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_we |-> r_state == S_IDLE || r_state == S_PAD)
        else $error("block buffer written during compression");
`endif

endmodule

@@ verif/tb_sha1_message_hasher_unit.sv @@
module tb_sha1_message_hasher_unit;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BEATS = 420;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } t_msg_beat;

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        fin;
    } t_digest_beat;

    logic i_clk;
    logic i_rst_n;

    sha1mh_in_if  in_if ();
    sha1mh_out_if out_if ();

    sha1_message_hasher_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // beats waiting to be offered, and digest words the hash must still return
    t_msg_beat    message_words[$];
    t_digest_beat pending_digest[$];

    // running SHA-1 state of the message in flight
    logic [31:0] chain_h [5];
    logic [31:0] block_w [16];
    logic [3:0]  block_pos;
    logic [63:0] msg_bit_len;

    int total_beats;
    int in_beats;
    int n_err;
    int stall_cycles;
    int hold_left;
    bit hold_done;
    logic steady;

    // no idling on either side for a stretch of one hundred input beats
    assign steady = (in_beats >= 200) && (in_beats < 300);

    task automatic restart_hash();
        chain_h[0]  = 32'h6745_2301;
        chain_h[1]  = 32'hEFCD_AB89;
        chain_h[2]  = 32'h98BA_DCFE;
        chain_h[3]  = 32'h1032_5476;
        chain_h[4]  = 32'hC3D2_E1F0;
        block_pos   = 4'd0;
        msg_bit_len = 64'd0;
    endtask

    task automatic fold_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, s, x;
        for (int t = 0; t < 16; t++) w[t] = block_w[t];
        for (int t = 16; t < 80; t++) begin
            x    = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
            w[t] = {x[30:0], x[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A82_7999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9_EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1B_BCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62_C1D6;
            end
            s = {a[26:0], a[31:27]} + f + e + k + w[t];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = s;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endtask

    task automatic buffer_word(input logic [31:0] w);
        block_w[block_pos] = w;
        block_pos = block_pos + 4'd1;
        if (block_pos == 4'd0) fold_block();
    endtask

    // advance the hash by one accepted beat; a final beat pads and yields the digest
    task automatic hash_beat(input logic [31:0] data, input logic [2:0] count,
                             input logic last);
        int           nbytes;
        logic [31:0]  keep;
        t_digest_beat dw;
        if (!last) begin
            buffer_word(data);
            msg_bit_len = msg_bit_len + 64'd32;
        end else begin
            nbytes = (count > 3'd4) ? 4 : int'(count);
            msg_bit_len = msg_bit_len + 64'(8 * nbytes);
            if (nbytes == 4) begin
                buffer_word(data);
                buffer_word(32'h8000_0000);
            end else begin
                keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
                buffer_word((data & keep) | (32'h80 << (24 - 8 * nbytes)));
            end
            while (block_pos != 4'd14) buffer_word(32'h0);
            buffer_word(msg_bit_len[63:32]);
            buffer_word(msg_bit_len[31:0]);
            for (int i = 0; i < 5; i++) begin
                dw.digest = chain_h[i];
                dw.index  = 3'(i);
                dw.fin    = (i == 4);
                pending_digest.push_back(dw);
            end
            restart_hash();
        end
    endtask

    task automatic queue_beat(input logic [31:0] data, input logic [2:0] count,
                              input logic last);
        t_msg_beat mb;
        mb.data  = data;
        mb.count = count;
        mb.last  = last;
        message_words.push_back(mb);
    endtask

    task automatic queue_random_message();
        int          len;
        logic [31:0] data;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20) : $urandom_range(21, 50);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0:       data = 32'h0;
                1:       data = 32'hFFFF_FFFF;
                default: data = $urandom;
            endcase
            // mostly full words; a stray short count on a middle word still counts four
            queue_beat(data, ($urandom_range(0, 9) < 7) ? 3'd4 : 3'($urandom_range(0, 7)),
                       1'b0);
        end
        queue_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    always @(posedge i_clk) begin : drive_words
        t_msg_beat nxt;
        logic      give;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                hash_beat(in_if.data_word, in_if.byte_count, in_if.end_of_message);
                in_beats <= in_beats + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                give = (message_words.size() > 0) && (steady || $urandom_range(0, 99) >= 29);
                if (give) begin
                    nxt = message_words.pop_front();
                    in_if.data_word      <= nxt.data;
                    in_if.byte_count     <= nxt.count;
                    in_if.end_of_message <= nxt.last;
                    in_if.valid          <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_digest
        t_digest_beat exp_w;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_digest.size() == 0) begin
                    $error("digest_word: nothing expected, got %h", out_if.digest_word);
                    n_err++;
                end else begin
                    exp_w = pending_digest.pop_front();
                    if (out_if.digest_word !== exp_w.digest) begin
                        $error("digest_word: expected %h, got %h",
                               exp_w.digest, out_if.digest_word);
                        n_err++;
                    end
                    if (out_if.word_index !== exp_w.index) begin
                        $error("word_index: expected %0d, got %0d",
                               exp_w.index, out_if.word_index);
                        n_err++;
                    end
                    if (out_if.final_word !== exp_w.fin) begin
                        $error("final_word: expected %0d, got %0d",
                               exp_w.fin, out_if.final_word);
                        n_err++;
                    end
                end
            end
            // hold off once for a long stretch so the block backs up into its input
            if (!hold_done && in_beats >= 100) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= steady || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_sha1_message_hasher_unit: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.data_word      = 32'h0;
        in_if.byte_count     = 3'd0;
        in_if.end_of_message = 1'b0;
        out_if.ready         = 1'b0;
        in_beats             = 0;
        n_err                = 0;
        stall_cycles         = 0;
        hold_left            = 0;
        hold_done            = 1'b0;
        restart_hash();

        // empty message, then single-word messages over every byte count
        queue_beat(32'hFFFF_FFFF, 3'd0, 1'b1);
        queue_beat(32'h6162_6300, 3'd3, 1'b1);
        queue_beat(32'hFFFF_FFFF, 3'd1, 1'b1);
        queue_beat(32'h0000_0000, 3'd2, 1'b1);
        queue_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
        queue_beat(32'hA5A5_A5A5, 3'd5, 1'b1);
        queue_beat(32'h5A5A_5A5A, 3'd6, 1'b1);
        queue_beat(32'hFFFF_FFFF, 3'd7, 1'b1);
        // short counts on middle words, closed by an empty final word
        queue_beat(32'h1234_5678, 3'd2, 1'b0);
        queue_beat(32'h9ABC_DEF0, 3'd3, 1'b0);
        queue_beat(32'hFFFF_FFFF, 3'd0, 1'b1);
        // 56 bytes: the length no longer fits, so padding spills into a second block
        for (int i = 0; i < 14; i++)
            queue_beat(i[0] ? 32'h0 : 32'hFFFF_FFFF, 3'd4, 1'b0);
        queue_beat(32'hFFFF_FFFF, 3'd0, 1'b1);

        while (message_words.size() < RANDOM_BEATS) queue_random_message();
        total_beats = message_words.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (in_beats < total_beats || pending_digest.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_err == 0 && pending_digest.size() == 0) begin
            $display("tb_sha1_message_hasher_unit: done, clean");
        end else begin
            $display("tb_sha1_message_hasher_unit: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sha1mh_pkg.sv
rtl/sha1mh_if.sv
rtl/sha1mh_ram.sv
rtl/sha1mh_round.sv
rtl/sha1_message_hasher_unit.sv
verif/tb_sha1_message_hasher_unit.sv
